// File: hdl/fts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

   // register indexes on the csr channel
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BAND_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_POLL_LIM  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_LEVEL = 2'd3;
   localparam int unsigned CSR_DATA_W = 18;

   localparam logic [17:0] BAND_LOW_RESET  = 18'd87500;
   localparam logic [17:0] BAND_HIGH_RESET = 18'd108000;
   localparam logic [8:0]  POLL_LIM_RESET  = 9'd300;
   localparam logic [3:0]  MIN_LEVEL_RESET = 4'd3;

   // request codes
   localparam logic [1:0] ACT_TUNE       = 2'd0;
   localparam logic [1:0] ACT_WRITE_DONE = 2'd1;
   localparam logic [1:0] ACT_READ_BACK  = 2'd2;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_OUT_RANGE = 3'd1,
      ST_WRITE_ERR = 3'd2,
      ST_READ_ERR  = 3'd3,
      ST_TIMEOUT   = 3'd4,
      ST_WEAK      = 3'd5,
      ST_FRAME     = 3'd6,
      ST_WAITING   = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_WRITE = 3'b010,
      PH_POLL  = 3'b100
   } phase_type;

   // pll word = floor((f_khz * 1000 + 225000) / 8192), low 14 bits
   localparam int unsigned HZ_W    = 28;
   localparam logic [9:0]  KHZ_MUL = 10'd1000;
   localparam logic [HZ_W-1:0] IF_HZ = 28'd225000;
   localparam int unsigned PLL_LSB = 13;
   localparam int unsigned PLL_W   = 14;

   localparam logic [7:0] FRAME3 = 8'h10;
   localparam logic [7:0] FRAME4 = 8'h16;
   localparam logic [7:0] FRAME5 = 8'h40;

   typedef struct packed {
      logic [17:0] band_low_khz;
      logic [17:0] band_high_khz;
      logic [8:0]  poll_limit;
      logic [3:0]  min_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [17:0] freq_khz;
      logic        bus_error;
      logic [7:0]  read_byte1;
      logic [7:0]  read_byte2;
      logic [7:0]  read_byte3;
      logic [7:0]  read_byte4;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  frame_byte1;
      logic [7:0]  frame_byte2;
      logic [7:0]  frame_byte3;
      logic [7:0]  frame_byte4;
      logic [7:0]  frame_byte5;
      logic [3:0]  signal_level;
      logic        is_stereo;
      logic [6:0]  if_count;
      logic        band_limit;
      logic [13:0] pll_readback;
      logic [8:0]  polls_taken;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/fts_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [17:0] freq_khz;
   logic        bus_error;
   logic [7:0]  read_byte1;
   logic [7:0]  read_byte2;
   logic [7:0]  read_byte3;
   logic [7:0]  read_byte4;

   modport source (
      output valid, action, freq_khz, bus_error,
             read_byte1, read_byte2, read_byte3, read_byte4,
      input  ready
   );
   modport sink (
      input  valid, action, freq_khz, bus_error,
             read_byte1, read_byte2, read_byte3, read_byte4,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/fts_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fts_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  frame_byte1;
   logic [7:0]  frame_byte2;
   logic [7:0]  frame_byte3;
   logic [7:0]  frame_byte4;
   logic [7:0]  frame_byte5;
   logic [3:0]  signal_level;
   logic        is_stereo;
   logic [6:0]  if_count;
   logic        band_limit;
   logic [13:0] pll_readback;
   logic [8:0]  polls_taken;

   modport source (
      output valid, status, frame_byte1, frame_byte2, frame_byte3, frame_byte4,
             frame_byte5, signal_level, is_stereo, if_count, band_limit,
             pll_readback, polls_taken,
      input  ready
   );
   modport sink (
      input  valid, status, frame_byte1, frame_byte2, frame_byte3, frame_byte4,
             frame_byte5, signal_level, is_stereo, if_count, band_limit,
             pll_readback, polls_taken,
      output ready
   );
endinterface

`default_nettype wire

// File: hdl/fts_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fts_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fts_pkg::CSR_INDEX_W-1:0]   reg_index;
   logic [fts_pkg::CSR_DATA_W-1:0]    write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input  valid, reg_index, write_data, output ready);
endinterface

`default_nettype wire

// File: hdl/fts_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module fts_csr (
   input  wire logic          clock,
   input  wire logic          reset,
   fts_csr_if.sink            csr_ch,
   output fts_pkg::cfg_type   cfg
);

   fts_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.reg_index)
            fts_pkg::REG_BAND_LOW:  cfg_in.band_low_khz  = csr_ch.write_data;
            fts_pkg::REG_BAND_HIGH: cfg_in.band_high_khz = csr_ch.write_data;
            fts_pkg::REG_POLL_LIM:  cfg_in.poll_limit    = csr_ch.write_data[8:0];
            fts_pkg::REG_MIN_LEVEL: cfg_in.min_level     = csr_ch.write_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_low_khz  <= fts_pkg::BAND_LOW_RESET;
         cfg_ff.band_high_khz <= fts_pkg::BAND_HIGH_RESET;
         cfg_ff.poll_limit    <= fts_pkg::POLL_LIM_RESET;
         cfg_ff.min_level     <= fts_pkg::MIN_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hdl/fts_step.sv
`timescale 1ns / 1ps
`default_nettype none

module fts_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire fts_pkg::req_type   req,
   input  wire fts_pkg::cfg_type   cfg,
   output fts_pkg::rsp_type        rsp
);

   fts_pkg::phase_type phase_ff, phase_in;
   logic [8:0] poll_cnt_ff, poll_cnt_in;

   logic [fts_pkg::HZ_W-1:0]  hz;
   logic [fts_pkg::PLL_W-1:0] pll;
   logic [8:0]                poll_next;
   logic [3:0]                level;
   logic                      out_of_band;

   assign hz = fts_pkg::HZ_W'(req.freq_khz) * fts_pkg::HZ_W'(fts_pkg::KHZ_MUL)
             + fts_pkg::IF_HZ;
   assign pll         = hz[fts_pkg::PLL_LSB +: fts_pkg::PLL_W];
   assign out_of_band = (req.freq_khz < cfg.band_low_khz) ||
                        (req.freq_khz > cfg.band_high_khz);
   assign poll_next   = poll_cnt_ff + 9'd1;
   assign level       = req.read_byte4[7:4];

   always_comb begin
      rsp         = '0;
      rsp.status  = fts_pkg::ST_WAITING;
      phase_in    = phase_ff;
      poll_cnt_in = poll_cnt_ff;
      case (req.action)
         fts_pkg::ACT_TUNE: begin
            // a tune request always restarts the sequence
            poll_cnt_in = '0;
            if (out_of_band) begin
               rsp.status = fts_pkg::ST_OUT_RANGE;
               phase_in   = fts_pkg::PH_IDLE;
            end else begin
               rsp.status      = fts_pkg::ST_FRAME;
               rsp.frame_byte1 = {2'b00, pll[13:8]};
               rsp.frame_byte2 = pll[7:0];
               rsp.frame_byte3 = fts_pkg::FRAME3;
               rsp.frame_byte4 = fts_pkg::FRAME4;
               rsp.frame_byte5 = fts_pkg::FRAME5;
               phase_in        = fts_pkg::PH_WRITE;
            end
         end
         fts_pkg::ACT_WRITE_DONE: begin
            if (phase_ff == fts_pkg::PH_WRITE) begin
               poll_cnt_in = '0;
               if (req.bus_error) begin
                  rsp.status = fts_pkg::ST_WRITE_ERR;
                  phase_in   = fts_pkg::PH_IDLE;
               end else if (cfg.poll_limit == '0) begin
                  rsp.status = fts_pkg::ST_TIMEOUT;
                  phase_in   = fts_pkg::PH_IDLE;
               end else begin
                  phase_in = fts_pkg::PH_POLL;
               end
            end
         end
         fts_pkg::ACT_READ_BACK: begin
            if (phase_ff == fts_pkg::PH_POLL) begin
               if (req.bus_error) begin
                  rsp.status  = fts_pkg::ST_READ_ERR;
                  phase_in    = fts_pkg::PH_IDLE;
                  poll_cnt_in = '0;
               end else if (req.read_byte1[7]) begin
                  rsp.status       = (level < cfg.min_level) ? fts_pkg::ST_WEAK
                                                             : fts_pkg::ST_OK;
                  rsp.signal_level = level;
                  rsp.is_stereo    = req.read_byte3[7];
                  rsp.if_count     = req.read_byte3[6:0];
                  rsp.band_limit   = req.read_byte1[6];
                  rsp.pll_readback = {req.read_byte1[5:0], req.read_byte2};
                  rsp.polls_taken  = poll_cnt_ff;
                  phase_in         = fts_pkg::PH_IDLE;
                  poll_cnt_in      = '0;
               end else if (poll_next >= cfg.poll_limit) begin
                  rsp.status  = fts_pkg::ST_TIMEOUT;
                  phase_in    = fts_pkg::PH_IDLE;
                  poll_cnt_in = '0;
               end else begin
                  poll_cnt_in = poll_next;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= fts_pkg::PH_IDLE;
         poll_cnt_ff <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         poll_cnt_ff <= poll_cnt_in;
      end
   end

   a_frame_enters_write: assert property (@(posedge clock) disable iff (reset)
      (step_en && rsp.status == fts_pkg::ST_FRAME) |=> phase_ff == fts_pkg::PH_WRITE)
      else $error("frame sent but sequence not waiting for write done");

   a_poll_only_in_poll: assert property (@(posedge clock) disable iff (reset)
      (poll_cnt_ff != '0) |-> phase_ff == fts_pkg::PH_POLL)
      else $error("poll count held outside polling");

   a_idle_after_end: assert property (@(posedge clock) disable iff (reset)
      (step_en && (rsp.status == fts_pkg::ST_OK || rsp.status == fts_pkg::ST_WEAK ||
                   rsp.status == fts_pkg::ST_TIMEOUT))
      |=> (phase_ff == fts_pkg::PH_IDLE && poll_cnt_ff == '0))
      else $error("sequence not closed after final status");

endmodule

`default_nettype wire

// File: hdl/fm_tuner_tune_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// pipeline: an accepted request is registered in s1, and its response is registered
// in the output register when that register is free or being read
// throughput: one request per cycle while the response side is ready; the step logic
// reads and updates phase and poll count for one registered request each such cycle
// reset: synchronous; clears the sequence to idle, the poll count to zero and
// the band, poll limit and level registers to their defaults

module fm_tuner_tune_sequencer (
   input  wire logic clock,
   input  wire logic reset,
   fts_req_if.sink   req_ch,
   fts_rsp_if.source rsp_ch,
   fts_csr_if.sink   csr_ch
);

   fts_pkg::cfg_type cfg;
   fts_pkg::rsp_type step_rsp;

   logic             s1_valid_ff, s1_valid_in;
   fts_pkg::req_type s1_req_ff;
   logic             out_valid_ff, out_valid_in;
   fts_pkg::rsp_type out_rsp_ff;

   logic out_take;
   logic step_en;
   logic req_take;

   assign out_take = !out_valid_ff || rsp_ch.ready;
   assign step_en  = s1_valid_ff && out_take;
   assign req_take = !s1_valid_ff || out_take;

   assign req_ch.ready = req_take;
   assign s1_valid_in  = req_take ? req_ch.valid : s1_valid_ff;
   assign out_valid_in = out_take ? s1_valid_ff : out_valid_ff;

   fts_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   fts_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (s1_req_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_ch.valid) begin
         s1_req_ff.action     <= req_ch.action;
         s1_req_ff.freq_khz   <= req_ch.freq_khz;
         s1_req_ff.bus_error  <= req_ch.bus_error;
         s1_req_ff.read_byte1 <= req_ch.read_byte1;
         s1_req_ff.read_byte2 <= req_ch.read_byte2;
         s1_req_ff.read_byte3 <= req_ch.read_byte3;
         s1_req_ff.read_byte4 <= req_ch.read_byte4;
      end
      if (step_en) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_rsp_ff.status;
   assign rsp_ch.frame_byte1  = out_rsp_ff.frame_byte1;
   assign rsp_ch.frame_byte2  = out_rsp_ff.frame_byte2;
   assign rsp_ch.frame_byte3  = out_rsp_ff.frame_byte3;
   assign rsp_ch.frame_byte4  = out_rsp_ff.frame_byte4;
   assign rsp_ch.frame_byte5  = out_rsp_ff.frame_byte5;
   assign rsp_ch.signal_level = out_rsp_ff.signal_level;
   assign rsp_ch.is_stereo    = out_rsp_ff.is_stereo;
   assign rsp_ch.if_count     = out_rsp_ff.if_count;
   assign rsp_ch.band_limit   = out_rsp_ff.band_limit;
   assign rsp_ch.pll_readback = out_rsp_ff.pll_readback;
   assign rsp_ch.polls_taken  = out_rsp_ff.polls_taken;

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_valid_ff)
      else $error("stepped request produced no response");

   a_stalled_request_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_take) |=> (s1_valid_ff && $stable(s1_req_ff)))
      else $error("registered request lost during output stall");

   a_frame_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rsp_ff.status != fts_pkg::ST_FRAME)
      |-> (out_rsp_ff.frame_byte1 == '0 && out_rsp_ff.frame_byte3 == '0))
      else $error("frame bytes set on a non-frame response");

   a_readback_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rsp_ff.status != fts_pkg::ST_OK &&
       out_rsp_ff.status != fts_pkg::ST_WEAK)
      |-> (out_rsp_ff.pll_readback == '0 && out_rsp_ff.polls_taken == '0))
      else $error("read-back fields set without a ready status");

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;

   typedef enum logic { ROW_REQ, ROW_CFG } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      fts_pkg::req_type     rq;
      logic [1:0]           idx;
      logic [17:0]          val;
      logic                 typed;
      fts_pkg::status_type  st;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fts_req_if req_bus ();
   fts_rsp_if rsp_bus ();
   fts_csr_if csr_bus ();

   fm_tuner_tune_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // shadow of the tuner state and registers
   fts_pkg::cfg_type    shadow_cfg;
   fts_pkg::phase_type  seq_phase;
   logic [8:0]          poll_count;

   fts_pkg::rsp_type expected_tuner_rsp [$];
   stim_row_type     directed_rows [$];

   int  req_count   = 0;
   int  rsp_checked = 0;
   int  errors      = 0;
   int  cycles      = 0;
   int  status_seen [8];
   bit  idle_on     = 1'b1;
   bit  quiet       = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("run stalled after %0d cycles, %0d responses pending", cycles,
                  expected_tuner_rsp.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic fts_pkg::rsp_type predict_tuner_rsp(fts_pkg::req_type r);
      fts_pkg::rsp_type o;
      logic [27:0] hz;
      logic [13:0] word;
      logic [3:0]  lvl;
      o = '0;
      o.status = fts_pkg::ST_WAITING;
      case (r.action)
         fts_pkg::ACT_TUNE: begin
            // a tune aborts whatever was going on
            poll_count = '0;
            if (r.freq_khz < shadow_cfg.band_low_khz ||
                r.freq_khz > shadow_cfg.band_high_khz) begin
               o.status = fts_pkg::ST_OUT_RANGE;
               seq_phase = fts_pkg::PH_IDLE;
            end else begin
               hz = 28'(r.freq_khz);
               hz = hz * fts_pkg::KHZ_MUL + fts_pkg::IF_HZ;
               word = hz[fts_pkg::PLL_LSB +: fts_pkg::PLL_W];
               o.status = fts_pkg::ST_FRAME;
               o.frame_byte1 = {2'b00, word[13:8]};
               o.frame_byte2 = word[7:0];
               o.frame_byte3 = fts_pkg::FRAME3;
               o.frame_byte4 = fts_pkg::FRAME4;
               o.frame_byte5 = fts_pkg::FRAME5;
               seq_phase = fts_pkg::PH_WRITE;
            end
         end
         fts_pkg::ACT_WRITE_DONE: begin
            if (seq_phase == fts_pkg::PH_WRITE) begin
               poll_count = '0;
               if (r.bus_error) begin
                  o.status = fts_pkg::ST_WRITE_ERR;
                  seq_phase = fts_pkg::PH_IDLE;
               end else if (shadow_cfg.poll_limit == 9'd0) begin
                  o.status = fts_pkg::ST_TIMEOUT;
                  seq_phase = fts_pkg::PH_IDLE;
               end else begin
                  seq_phase = fts_pkg::PH_POLL;
               end
            end
         end
         fts_pkg::ACT_READ_BACK: begin
            if (seq_phase == fts_pkg::PH_POLL) begin
               if (r.bus_error) begin
                  o.status = fts_pkg::ST_READ_ERR;
                  seq_phase = fts_pkg::PH_IDLE;
                  poll_count = '0;
               end else if (r.read_byte1[7]) begin
                  lvl = r.read_byte4[7:4];
                  o.status = (lvl < shadow_cfg.min_level) ? fts_pkg::ST_WEAK
                                                          : fts_pkg::ST_OK;
                  o.signal_level = lvl;
                  o.is_stereo = r.read_byte3[7];
                  o.if_count = r.read_byte3[6:0];
                  o.band_limit = r.read_byte1[6];
                  o.pll_readback = {r.read_byte1[5:0], r.read_byte2};
                  o.polls_taken = poll_count;
                  seq_phase = fts_pkg::PH_IDLE;
                  poll_count = '0;
               end else begin
                  poll_count = poll_count + 9'd1;
                  if (poll_count >= shadow_cfg.poll_limit) begin
                     o.status = fts_pkg::ST_TIMEOUT;
                     seq_phase = fts_pkg::PH_IDLE;
                     poll_count = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic string fmt_rsp(fts_pkg::rsp_type x);
      return $sformatf({"st=%0d frame=%h.%h.%h.%h.%h lvl=%0d stereo=%b if=%0d",
                        " blim=%b pll=%h polls=%0d"},
                       x.status, x.frame_byte1, x.frame_byte2, x.frame_byte3,
                       x.frame_byte4, x.frame_byte5, x.signal_level, x.is_stereo,
                       x.if_count, x.band_limit, x.pll_readback, x.polls_taken);
   endfunction

   function automatic fts_pkg::req_type random_req();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(fts_pkg::req_type)-1:0];
   endfunction

   function automatic stim_row_type req_row(logic [1:0] act, logic [17:0] freq,
                                            logic berr, logic [31:0] bytes);
      stim_row_type s;
      s = '0;
      s.kind = ROW_REQ;
      s.rq.action = act;
      s.rq.freq_khz = freq;
      s.rq.bus_error = berr;
      {s.rq.read_byte1, s.rq.read_byte2, s.rq.read_byte3, s.rq.read_byte4} = bytes;
      return s;
   endfunction

   function automatic stim_row_type cfg_row(logic [1:0] idx, logic [17:0] val);
      stim_row_type s;
      s = '0;
      s.kind = ROW_CFG;
      s.idx = idx;
      s.val = val;
      return s;
   endfunction

   function automatic stim_row_type fixed(stim_row_type s, fts_pkg::status_type st);
      s.typed = 1'b1;
      s.st = st;
      return s;
   endfunction

   // random gap after a request, only while idling is enabled
   task automatic pace();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic send_req(fts_pkg::req_type r, logic typed,
                           fts_pkg::status_type typed_st);
      fts_pkg::rsp_type want;
      fts_pkg::rsp_type fixed_rsp;
      req_bus.valid      <= 1'b1;
      req_bus.action     <= r.action;
      req_bus.freq_khz   <= r.freq_khz;
      req_bus.bus_error  <= r.bus_error;
      req_bus.read_byte1 <= r.read_byte1;
      req_bus.read_byte2 <= r.read_byte2;
      req_bus.read_byte3 <= r.read_byte3;
      req_bus.read_byte4 <= r.read_byte4;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      want = predict_tuner_rsp(r);
      if (typed) begin
         fixed_rsp = '0;
         fixed_rsp.status = typed_st;
         expected_tuner_rsp.push_back(fixed_rsp);
      end else begin
         expected_tuner_rsp.push_back(want);
      end
      req_count++;
      pace();
   endtask

   task automatic write_reg(logic [1:0] idx, logic [17:0] val);
      req_bus.valid <= 1'b0;
      while (expected_tuner_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= idx;
      csr_bus.write_data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (idx)
         fts_pkg::REG_BAND_LOW:  shadow_cfg.band_low_khz  = val;
         fts_pkg::REG_BAND_HIGH: shadow_cfg.band_high_khz = val;
         fts_pkg::REG_POLL_LIM:  shadow_cfg.poll_limit    = val[8:0];
         fts_pkg::REG_MIN_LEVEL: shadow_cfg.min_level     = val[3:0];
         default: begin
         end
      endcase
   endtask

   // tune, write done, up to 24 not-ready polls, then ready or a read failure; stops early when the phase is left
   task automatic run_tune_sequence();
      fts_pkg::req_type r;
      int               n;
      r = random_req();
      r.action = fts_pkg::ACT_TUNE;
      if (shadow_cfg.band_low_khz <= shadow_cfg.band_high_khz && $urandom_range(0, 7) != 0)
         r.freq_khz = 18'($urandom_range(shadow_cfg.band_high_khz,
                                         shadow_cfg.band_low_khz));
      send_req(r, 1'b0, fts_pkg::ST_OK);
      if (seq_phase != fts_pkg::PH_WRITE || $urandom_range(0, 11) == 0) return;

      r = random_req();
      r.action = fts_pkg::ACT_WRITE_DONE;
      r.bus_error = ($urandom_range(0, 9) == 0);
      send_req(r, 1'b0, fts_pkg::ST_OK);
      if (seq_phase != fts_pkg::PH_POLL) return;

      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         r = random_req();
         if ($urandom_range(0, 11) == 0) begin
            // stray write done or unused code while polling
            r.action = ($urandom_range(0, 1) == 0) ? fts_pkg::ACT_WRITE_DONE : ACT_UNUSED;
         end else begin
            r.action = fts_pkg::ACT_READ_BACK;
            r.bus_error = 1'b0;
            r.read_byte1[7] = 1'b0;
         end
         send_req(r, 1'b0, fts_pkg::ST_OK);
         if (seq_phase != fts_pkg::PH_POLL) return;
      end

      r = random_req();
      r.action = fts_pkg::ACT_READ_BACK;
      r.bus_error = ($urandom_range(0, 9) == 0);
      if (!r.bus_error) r.read_byte1[7] = 1'b1;
      send_req(r, 1'b0, fts_pkg::ST_OK);
   endtask

   task automatic run_random(int count);
      int stop_at;
      stop_at = req_count + count;
      while (req_count < stop_at) begin
         if (!quiet && $urandom_range(0, 49) == 0) idle_on = !idle_on;
         if ($urandom_range(0, 7) == 0) send_req(random_req(), 1'b0, fts_pkg::ST_OK);
         else run_tune_sequence();
      end
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      fts_pkg::rsp_type got;
      fts_pkg::rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status       = fts_pkg::status_type'(rsp_bus.status);
         got.frame_byte1  = rsp_bus.frame_byte1;
         got.frame_byte2  = rsp_bus.frame_byte2;
         got.frame_byte3  = rsp_bus.frame_byte3;
         got.frame_byte4  = rsp_bus.frame_byte4;
         got.frame_byte5  = rsp_bus.frame_byte5;
         got.signal_level = rsp_bus.signal_level;
         got.is_stereo    = rsp_bus.is_stereo;
         got.if_count     = rsp_bus.if_count;
         got.band_limit   = rsp_bus.band_limit;
         got.pll_readback = rsp_bus.pll_readback;
         got.polls_taken  = rsp_bus.polls_taken;
         if (expected_tuner_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("response with none pending: %s", fmt_rsp(got));
         end else begin
            want = expected_tuner_rsp.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("response %0d mismatch\n  expected %s\n  actual   %s",
                           rsp_checked, fmt_rsp(want), fmt_rsp(got));
            end
            status_seen[want.status]++;
            rsp_checked++;
         end
      end
   end

   // response side back-pressure
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.action     <= fts_pkg::ACT_TUNE;
      req_bus.freq_khz   <= '0;
      req_bus.bus_error  <= 1'b0;
      req_bus.read_byte1 <= '0;
      req_bus.read_byte2 <= '0;
      req_bus.read_byte3 <= '0;
      req_bus.read_byte4 <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.reg_index  <= fts_pkg::REG_BAND_LOW;
      csr_bus.write_data <= '0;

      shadow_cfg.band_low_khz  = fts_pkg::BAND_LOW_RESET;
      shadow_cfg.band_high_khz = fts_pkg::BAND_HIGH_RESET;
      shadow_cfg.poll_limit    = fts_pkg::POLL_LIM_RESET;
      shadow_cfg.min_level     = fts_pkg::MIN_LEVEL_RESET;
      seq_phase  = fts_pkg::PH_IDLE;
      poll_count = '0;
      foreach (status_seen[i]) status_seen[i] = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // out-of-phase requests straight after reset, then band edges
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_WRITE_DONE, 18'd0, 1'b0, 32'h0),
                                    fts_pkg::ST_WAITING));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_READ_BACK, 18'd0, 1'b0,
                                            32'hFFFF_FFFF), fts_pkg::ST_WAITING));
      directed_rows.push_back(fixed(req_row(ACT_UNUSED, 18'h3FFFF, 1'b1, 32'hFFFF_FFFF),
                                    fts_pkg::ST_WAITING));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_TUNE, 18'd87499, 1'b0, 32'h0),
                                    fts_pkg::ST_OUT_RANGE));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_TUNE, 18'd108001, 1'b0, 32'h0),
                                    fts_pkg::ST_OUT_RANGE));
      directed_rows.push_back(req_row(fts_pkg::ACT_TUNE, 18'd87500, 1'b0, 32'h0));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_READ_BACK, 18'd0, 1'b0,
                                            32'hFFFF_FFFF), fts_pkg::ST_WAITING));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_WRITE_DONE, 18'd0, 1'b1, 32'h0),
                                    fts_pkg::ST_WRITE_ERR));
      directed_rows.push_back(req_row(fts_pkg::ACT_TUNE, 18'd108000, 1'b0, 32'h0));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_WRITE_DONE, 18'd0, 1'b0, 32'h0),
                                    fts_pkg::ST_WAITING));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_READ_BACK, 18'd0, 1'b0,
                                            32'h7FFF_FFFF), fts_pkg::ST_WAITING));
      directed_rows.push_back(req_row(fts_pkg::ACT_READ_BACK, 18'd0, 1'b0, 32'hFFFF_FFFF));
      directed_rows.push_back(req_row(fts_pkg::ACT_TUNE, 18'd100000, 1'b0, 32'h0));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_WRITE_DONE, 18'd0, 1'b0, 32'h0),
                                    fts_pkg::ST_WAITING));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_READ_BACK, 18'd0, 1'b1,
                                            32'hFFFF_FFFF), fts_pkg::ST_READ_ERR));
      // a tune while polling restarts the sequence
      directed_rows.push_back(req_row(fts_pkg::ACT_TUNE, 18'd95000, 1'b0, 32'h0));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_WRITE_DONE, 18'd0, 1'b0, 32'h0),
                                    fts_pkg::ST_WAITING));
      directed_rows.push_back(req_row(fts_pkg::ACT_TUNE, 18'd96000, 1'b0, 32'h0));
      directed_rows.push_back(cfg_row(fts_pkg::REG_POLL_LIM, 18'd1));
      directed_rows.push_back(cfg_row(fts_pkg::REG_BAND_LOW, 18'd0));
      directed_rows.push_back(cfg_row(fts_pkg::REG_BAND_HIGH, 18'h3FFFF));
      directed_rows.push_back(cfg_row(fts_pkg::REG_MIN_LEVEL, 18'd0));
      directed_rows.push_back(req_row(fts_pkg::ACT_TUNE, 18'd0, 1'b0, 32'h0));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_WRITE_DONE, 18'd0, 1'b0, 32'h0),
                                    fts_pkg::ST_WAITING));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_READ_BACK, 18'd0, 1'b0, 32'h0),
                                    fts_pkg::ST_TIMEOUT));
      // top of the range, pll word wraps
      directed_rows.push_back(req_row(fts_pkg::ACT_TUNE, 18'h3FFFF, 1'b0, 32'h0));
      directed_rows.push_back(cfg_row(fts_pkg::REG_POLL_LIM, 18'd0));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_WRITE_DONE, 18'd0, 1'b0, 32'h0),
                                    fts_pkg::ST_TIMEOUT));
      // inverted band rejects everything
      directed_rows.push_back(cfg_row(fts_pkg::REG_BAND_LOW, 18'h3FFFF));
      directed_rows.push_back(cfg_row(fts_pkg::REG_BAND_HIGH, 18'd0));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_TUNE, 18'd100000, 1'b0, 32'h0),
                                    fts_pkg::ST_OUT_RANGE));
      directed_rows.push_back(cfg_row(fts_pkg::REG_BAND_LOW, 18'd100000));
      directed_rows.push_back(cfg_row(fts_pkg::REG_BAND_HIGH, 18'd100000));
      directed_rows.push_back(cfg_row(fts_pkg::REG_MIN_LEVEL, 18'd15));
      directed_rows.push_back(cfg_row(fts_pkg::REG_POLL_LIM, 18'd511));
      directed_rows.push_back(req_row(fts_pkg::ACT_TUNE, 18'd100000, 1'b0, 32'h0));
      directed_rows.push_back(fixed(req_row(fts_pkg::ACT_WRITE_DONE, 18'd0, 1'b0, 32'h0),
                                    fts_pkg::ST_WAITING));
      directed_rows.push_back(req_row(fts_pkg::ACT_READ_BACK, 18'd0, 1'b0, 32'h8000_00E0));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG)
            write_reg(directed_rows[i].idx, directed_rows[i].val);
         else
            send_req(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].st);
      end

      write_reg(fts_pkg::REG_BAND_LOW, fts_pkg::BAND_LOW_RESET);
      write_reg(fts_pkg::REG_BAND_HIGH, fts_pkg::BAND_HIGH_RESET);
      write_reg(fts_pkg::REG_POLL_LIM, 18'(fts_pkg::POLL_LIM_RESET));
      write_reg(fts_pkg::REG_MIN_LEVEL, 18'(fts_pkg::MIN_LEVEL_RESET));
      run_random(130);

      write_reg(fts_pkg::REG_BAND_LOW, 18'd0);
      write_reg(fts_pkg::REG_BAND_HIGH, 18'h3FFFF);
      write_reg(fts_pkg::REG_POLL_LIM, 18'd4);
      write_reg(fts_pkg::REG_MIN_LEVEL, 18'd0);
      run_random(110);

      for (int k = 0; k < 2; k++) begin
         int lo;
         lo = $urandom_range(0, 200000);
         write_reg(fts_pkg::REG_BAND_LOW, 18'(lo));
         write_reg(fts_pkg::REG_BAND_HIGH, 18'(lo + $urandom_range(0, 60000)));
         write_reg(fts_pkg::REG_POLL_LIM, 18'($urandom_range(1, 12)));
         write_reg(fts_pkg::REG_MIN_LEVEL, 18'($urandom_range(0, 15)));
         run_random(60);
      end

      write_reg(fts_pkg::REG_BAND_LOW, 18'($urandom_range(150000, 262143)));
      write_reg(fts_pkg::REG_BAND_HIGH, 18'($urandom_range(0, 149999)));
      write_reg(fts_pkg::REG_POLL_LIM, 18'd511);
      write_reg(fts_pkg::REG_MIN_LEVEL, 18'd15);
      run_random(30);

      // closing stretch at full rate on both sides
      quiet = 1'b1;
      idle_on = 1'b0;
      write_reg(fts_pkg::REG_BAND_LOW, fts_pkg::BAND_LOW_RESET);
      write_reg(fts_pkg::REG_BAND_HIGH, fts_pkg::BAND_HIGH_RESET);
      write_reg(fts_pkg::REG_POLL_LIM, 18'd2);
      write_reg(fts_pkg::REG_MIN_LEVEL, 18'd8);
      run_random(120);

      req_bus.valid <= 1'b0;
      while (expected_tuner_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, %0d mismatches, %0d cycles",
               req_count, rsp_checked, errors, cycles);
      $display({"by status: ok %0d, out of band %0d, write fail %0d, read fail %0d,",
                " timeout %0d, weak %0d, frame %0d, waiting %0d"},
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
      if (errors == 0 && expected_tuner_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/fts_pkg.sv
hdl/fts_req_if.sv
hdl/fts_rsp_if.sv
hdl/fts_csr_if.sv
hdl/fts_csr.sv
hdl/fts_step.sv
hdl/fm_tuner_tune_sequencer.sv
tb/sv/testbench.sv
